// File: hdl/dbsp_pkg.sv
// ----------------------------------------------------------------------------
// dbsp_pkg
// shared types and constants of the bouquet table section parser
// ----------------------------------------------------------------------------
package dbsp_pkg;

	localparam logic [7:0] TAG_NAME     = 8'h47;
	localparam logic [7:0] TAG_SERVICES = 8'h41;

	localparam logic [1:0] KIND_VERSION = 2'd0;
	localparam logic [1:0] KIND_NAME    = 2'd1;
	localparam logic [1:0] KIND_SERVICE = 2'd2;
	localparam logic [1:0] KIND_CHANNEL = 2'd3;

	localparam logic [1:0] CFG_TABLE_ID = 2'd0;
	localparam logic [1:0] CFG_PRIV_TAG = 2'd1;
	localparam logic [1:0] CFG_FIXED_BQ = 2'd2;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] bouquet_id;
		logic [4:0]  version;
		logic [7:0]  name_byte;
		logic [4:0]  name_length;
		logic [15:0] svc_id;
		logic [15:0] channel_number;
		logic [1:0]  audio_track;
		logic [7:0]  volume_offset;
		logic        last_of_name;
	} rec_t;

endpackage

// File: hdl/dbsp_front.sv
// ----------------------------------------------------------------------------
// dbsp_front
// section byte parser: tracks header, descriptor loops and entries per word
// ----------------------------------------------------------------------------
module dbsp_front #(
	parameter int NAME_MAX = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_go,
	input  logic [7:0]           data_byte,
	input  logic                 section_start,
	input  logic [7:0]           table_id_q,
	input  logic [7:0]           priv_tag_q,
	input  logic [15:0]          fixed_bq_q,
	output logic                 rec_valid,
	output dbsp_pkg::rec_t       rec
);

	localparam int NW = $clog2(NAME_MAX + 1);

	typedef enum logic [10:0] {
		PH_IDLE   = 11'b00000000001,
		PH_SECLEN = 11'b00000000010,
		PH_BQID   = 11'b00000000100,
		PH_VER    = 11'b00000001000,
		PH_SECNUM = 11'b00000010000,
		PH_BLEN   = 11'b00000100000,
		PH_DTAG   = 11'b00001000000,
		PH_DLEN   = 11'b00010000000,
		PH_DBODY  = 11'b00100000000,
		PH_TSLEN  = 11'b01000000000,
		PH_TSHDR  = 11'b10000000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [15:0] bq_q, bq_d;
	logic [7:0]  tag_q, tag_d;
	logic [7:0]  drem_q, drem_d;
	logic [11:0] blrem_q, blrem_d;
	logic [11:0] slrem_q, slrem_d;
	logic [11:0] sdrem_q, sdrem_d;
	logic [47:0] sh_q, sh_d;
	logic [NW-1:0] ncnt_q, ncnt_d, ntot_q, ntot_d;
	logic        ins_q, ins_d;

	logic [47:0] shn;
	logic [11:0] bl1, sl1, sd1, left1;
	logic        ended;
	logic [2:0]  cnt1;
	logic [7:0]  trk;
	logic [11:0] ts_sd;

	always_comb begin
		shn = {sh_q[39:0], data_byte};
		cnt1 = cnt_q + 3'd1;
		bl1 = (blrem_q != 12'd0) ? blrem_q - 12'd1 : 12'd0;
		sl1 = (slrem_q != 12'd0) ? slrem_q - 12'd1 : 12'd0;
		sd1 = (sdrem_q != 12'd0) ? sdrem_q - 12'd1 : 12'd0;
		ended = ins_q ? (sd1 == 12'd0) : (bl1 == 12'd0);
		left1 = ins_q ? sd1 : bl1;
		trk = shn[15:8];
		ts_sd = (shn[11:0] > sl1) ? sl1 : shn[11:0];
		phase_d = phase_q; cnt_d = cnt_q; bq_d = bq_q; tag_d = tag_q;
		drem_d = drem_q; blrem_d = blrem_q; slrem_d = slrem_q; sdrem_d = sdrem_q;
		sh_d = sh_q; ncnt_d = ncnt_q; ntot_d = ntot_q; ins_d = ins_q;
		rec_valid = 1'b0;
		rec = '0;
		rec.bouquet_id = bq_q;
		if (section_start) begin
			ins_d = 1'b0; cnt_d = '0; sh_d = '0;
			phase_d = (data_byte == table_id_q) ? PH_SECLEN : PH_IDLE;
		end else begin
			case (phase_q)
				PH_SECLEN, PH_SECNUM: begin
					cnt_d = cnt1;
					if (cnt1 >= 3'd2) begin
						cnt_d = '0;
						phase_d = (phase_q == PH_SECLEN) ? PH_BQID : PH_BLEN;
					end
				end
				PH_BQID: begin
					sh_d = shn; cnt_d = cnt1;
					if (cnt1 >= 3'd2) begin
						cnt_d = '0; bq_d = shn[15:0]; phase_d = PH_VER;
					end
				end
				PH_VER: begin
					rec_valid = 1'b1;
					rec.record_kind = dbsp_pkg::KIND_VERSION;
					rec.version = data_byte[5:1];
					phase_d = PH_SECNUM;
				end
				PH_BLEN: begin
					sh_d = shn; cnt_d = cnt1;
					if (cnt1 >= 3'd2) begin
						cnt_d = '0; blrem_d = shn[11:0]; ins_d = 1'b0;
						phase_d = (shn[11:0] == 12'd0) ? PH_TSLEN : PH_DTAG;
					end
				end
				PH_DTAG, PH_DLEN, PH_DBODY: begin
					if (ins_q) begin
						sdrem_d = sd1; slrem_d = sl1;
					end else begin
						blrem_d = bl1;
					end
					if (phase_q == PH_DTAG) begin
						tag_d = data_byte; phase_d = PH_DLEN;
					end else if (phase_q == PH_DLEN) begin
						drem_d = ({4'd0, data_byte} > left1) ? left1[7:0] : data_byte;
						cnt_d = '0; sh_d = '0; ncnt_d = '0;
						ntot_d = ({24'd0, drem_d} > NAME_MAX) ? NW'(NAME_MAX) : NW'(drem_d);
						if (tag_q == dbsp_pkg::TAG_NAME && drem_d == 8'd0) begin
							rec_valid = 1'b1;
							rec.record_kind = dbsp_pkg::KIND_NAME;
							rec.last_of_name = 1'b1;
						end
						phase_d = (drem_d == 8'd0) ? PH_DTAG : PH_DBODY;
					end else begin
						drem_d = (drem_q != 8'd0) ? drem_q - 8'd1 : 8'd0;
						if (tag_q == dbsp_pkg::TAG_NAME) begin
							if (ncnt_q < ntot_q) begin
								rec_valid = 1'b1;
								rec.record_kind = dbsp_pkg::KIND_NAME;
								rec.name_byte = data_byte;
								rec.name_length = 5'(ntot_q);
								rec.last_of_name = (ncnt_q + 1'b1 == ntot_q);
								ncnt_d = ncnt_q + 1'b1;
							end
						end else if (tag_q == dbsp_pkg::TAG_SERVICES) begin
							sh_d = shn; cnt_d = cnt1;
							if (cnt1 >= 3'd3) begin
								cnt_d = '0;
								rec_valid = 1'b1;
								rec.record_kind = dbsp_pkg::KIND_SERVICE;
								rec.svc_id = shn[23:8];
							end
						end else if (tag_q == priv_tag_q) begin
							sh_d = shn; cnt_d = cnt1;
							if (cnt1 >= 3'd6) begin
								cnt_d = '0; bq_d = fixed_bq_q;
								rec_valid = 1'b1;
								rec.record_kind = dbsp_pkg::KIND_CHANNEL;
								rec.bouquet_id = fixed_bq_q;
								rec.svc_id = shn[47:32];
								rec.channel_number = shn[31:16];
								rec.audio_track = (trk <= 8'd2) ? trk[1:0] : 2'd1;
								rec.volume_offset = shn[7:0];
							end
						end
						if (drem_d == 8'd0) phase_d = PH_DTAG;
					end
					if (ended) begin
						cnt_d = '0; sh_d = '0;
						if (!ins_q) begin
							phase_d = PH_TSLEN;
						end else begin
							ins_d = 1'b0;
							phase_d = (sl1 == 12'd0) ? PH_IDLE : PH_TSHDR;
						end
					end
				end
				PH_TSLEN: begin
					sh_d = shn; cnt_d = cnt1;
					if (cnt1 >= 3'd2) begin
						cnt_d = '0; slrem_d = shn[11:0];
						phase_d = (shn[11:0] == 12'd0) ? PH_IDLE : PH_TSHDR;
					end
				end
				PH_TSHDR: begin
					sh_d = shn; cnt_d = cnt1; slrem_d = sl1;
					if (cnt1 >= 3'd6) begin
						cnt_d = '0; sdrem_d = ts_sd; sh_d = '0;
						if (ts_sd != 12'd0) begin
							ins_d = 1'b1; phase_d = PH_DTAG;
						end else if (sl1 == 12'd0) begin
							phase_d = PH_IDLE;
						end
					end else if (sl1 == 12'd0) begin
						cnt_d = '0; phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cnt_q <= '0; bq_q <= '0; tag_q <= '0;
			drem_q <= '0; blrem_q <= '0; slrem_q <= '0; sdrem_q <= '0;
			sh_q <= '0; ncnt_q <= '0; ntot_q <= '0; ins_q <= 1'b0;
		end else if (in_go) begin
			phase_q <= phase_d; cnt_q <= cnt_d; bq_q <= bq_d; tag_q <= tag_d;
			drem_q <= drem_d; blrem_q <= blrem_d; slrem_q <= slrem_d;
			sdrem_q <= sdrem_d; sh_q <= sh_d; ncnt_q <= ncnt_d;
			ntot_q <= ntot_d; ins_q <= ins_d;
		end
	end

endmodule

// File: hdl/dbsp_queue.sv
// ----------------------------------------------------------------------------
// dbsp_queue
// two-entry record queue between parser and output port
// ----------------------------------------------------------------------------
module dbsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dbsp_pkg::rec_t wr_rec,
	output logic           full,
	output logic           rd_valid,
	output dbsp_pkg::rec_t rd_rec,
	input  logic           rd_en
);

	dbsp_pkg::rec_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_rec = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// File: hdl/dvb_bat_section_parser_top.sv
// ----------------------------------------------------------------------------
// dvb_bat_section_parser_top
// bouquet association table section parser, one section byte per word
// ----------------------------------------------------------------------------
// input channel: data_byte and section_start, qualified by in_valid/in_stall.
// section_start marks the table id byte; sections with another table id are
// dropped. output channel: one record word per emitted version, name byte,
// service entry or channel number entry, qualified by out_valid/out_stall.
// throughput is one byte per cycle while in_stall is low; the parser state
// updates per byte and its record is registered into a two-entry queue,
// from which the output port reads it.
// when the receiver stalls the queue fills and in_stall rises once it is
// full; bytes are then held off until a record drains.
// reset clears the parser to idle, empties the queue and loads the register
// defaults: table id 0x4a, private tag 0x80, fixed bouquet id 800.
// configuration is written with cfg_we, cfg_index and cfg_data while idle.
// ----------------------------------------------------------------------------
module dvb_bat_section_parser_top #(
	parameter int NAME_MAX = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        section_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [15:0] bouquet_id,
	output logic [4:0]  version,
	output logic [7:0]  name_byte,
	output logic [4:0]  name_length,
	output logic [15:0] svc_id,
	output logic [15:0] channel_number,
	output logic [1:0]  audio_track,
	output logic signed [7:0] volume_offset,
	output logic        last_of_name
);

	logic [7:0]  table_id_q, priv_tag_q;
	logic [15:0] fixed_bq_q;
	logic in_go, rec_valid, full, rd_en;
	dbsp_pkg::rec_t rec, orec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_id_q <= 8'h4A; priv_tag_q <= 8'h80; fixed_bq_q <= 16'd800;
		end else if (cfg_we) begin
			case (cfg_index)
				dbsp_pkg::CFG_TABLE_ID: table_id_q <= cfg_data[7:0];
				dbsp_pkg::CFG_PRIV_TAG: priv_tag_q <= cfg_data[7:0];
				dbsp_pkg::CFG_FIXED_BQ: fixed_bq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign in_go = in_valid && !full;
	assign rd_en = out_valid && !out_stall;

	dbsp_front #(.NAME_MAX(NAME_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .data_byte(data_byte),
		.section_start(section_start), .table_id_q(table_id_q),
		.priv_tag_q(priv_tag_q), .fixed_bq_q(fixed_bq_q),
		.rec_valid(rec_valid), .rec(rec)
	);

	dbsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(in_go && rec_valid), .wr_rec(rec),
		.full(full), .rd_valid(out_valid), .rd_rec(orec), .rd_en(rd_en)
	);

	assign record_kind    = orec.record_kind;
	assign bouquet_id     = orec.bouquet_id;
	assign version        = orec.version;
	assign name_byte      = orec.name_byte;
	assign name_length    = orec.name_length;
	assign svc_id         = orec.svc_id;
	assign channel_number = orec.channel_number;
	assign audio_track    = orec.audio_track;
	assign volume_offset  = orec.volume_offset;
	assign last_of_name   = orec.last_of_name;

endmodule

// File: tb/dvb_bat_section_parser_top_test.sv
// ----------------------------------------------------------------------------
// dvb_bat_section_parser_top_test
// self-checking testbench of the bouquet association table section parser
// ----------------------------------------------------------------------------
// feeds a short directed section, then random well-formed, cut and foreign
// sections mixed with stray bytes, under several register settings and
// sender/receiver idling patterns. a scoreboard class keeps its own model
// of the parser, predicts every record word and checks each output word
// against it in order. a watchdog ends the run when nothing moves.
// ----------------------------------------------------------------------------
module dvb_bat_section_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_LIMIT = 30;
	localparam int WATCHDOG_CYCLES = 5000;

	typedef enum int {
		ST_IDLE, ST_SECLEN, ST_BQID, ST_VER, ST_SECNUM, ST_BLEN,
		ST_DTAG, ST_DLEN, ST_DBODY, ST_TSLEN, ST_TSHDR
	} bat_state_t;

	class bat_scoreboard;
		logic [7:0]  tid_reg;
		logic [7:0]  priv_tag_reg;
		logic [15:0] fixed_bq_reg;
		bat_state_t  state;
		int unsigned byte_cnt;
		logic [15:0] bouquet;
		logic [7:0]  tag;
		int unsigned desc_left;
		int unsigned bq_loop_left;
		int unsigned ts_loop_left;
		int unsigned ts_desc_left;
		logic [47:0] shift;
		int unsigned name_cnt;
		int unsigned name_len;
		bit          in_ts;
		dbsp_pkg::rec_t record_q[$];
		int          mismatches;
		int          records_seen;

		function new();
			tid_reg = 8'h4a;
			priv_tag_reg = 8'h80;
			fixed_bq_reg = 16'd800;
			state = ST_IDLE;
			byte_cnt = 0;
			bouquet = 0;
			tag = 0;
			desc_left = 0;
			bq_loop_left = 0;
			ts_loop_left = 0;
			ts_desc_left = 0;
			shift = 0;
			name_cnt = 0;
			name_len = 0;
			in_ts = 0;
			mismatches = 0;
			records_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == dbsp_pkg::CFG_TABLE_ID) tid_reg = val[7:0];
			else if (idx == dbsp_pkg::CFG_PRIV_TAG) priv_tag_reg = val[7:0];
			else if (idx == dbsp_pkg::CFG_FIXED_BQ) fixed_bq_reg = val;
		endfunction

		function dbsp_pkg::rec_t blank(logic [1:0] kind);
			dbsp_pkg::rec_t r;
			r = '0;
			r.record_kind = kind;
			r.bouquet_id = bouquet;
			return r;
		endfunction

		function bit count_loop();
			if (in_ts) begin
				if (ts_desc_left > 0) ts_desc_left--;
				if (ts_loop_left > 0) ts_loop_left--;
				return ts_desc_left == 0;
			end
			if (bq_loop_left > 0) bq_loop_left--;
			return bq_loop_left == 0;
		endfunction

		function void close_loop();
			byte_cnt = 0;
			shift = 0;
			if (!in_ts) state = ST_TSLEN;
			else begin
				in_ts = 0;
				state = (ts_loop_left == 0) ? ST_IDLE : ST_TSHDR;
			end
		endfunction

		function void note_byte(logic [7:0] b, logic s);
			dbsp_pkg::rec_t r;
			bit ended;
			int unsigned left;
			logic [7:0] trk;
			if (s) begin
				in_ts = 0;
				byte_cnt = 0;
				shift = 0;
				state = (b == tid_reg) ? ST_SECLEN : ST_IDLE;
				return;
			end
			case (state)
				ST_SECLEN, ST_SECNUM: begin
					byte_cnt++;
					if (byte_cnt >= 2) begin
						byte_cnt = 0;
						state = (state == ST_SECLEN) ? ST_BQID : ST_BLEN;
					end
				end
				ST_BQID: begin
					shift = {shift[39:0], b};
					byte_cnt++;
					if (byte_cnt >= 2) begin
						byte_cnt = 0;
						bouquet = shift[15:0];
						state = ST_VER;
					end
				end
				ST_VER: begin
					r = blank(dbsp_pkg::KIND_VERSION);
					r.version = b[5:1];
					record_q.push_back(r);
					state = ST_SECNUM;
				end
				ST_BLEN: begin
					shift = {shift[39:0], b};
					byte_cnt++;
					if (byte_cnt >= 2) begin
						byte_cnt = 0;
						bq_loop_left = shift[11:0];
						in_ts = 0;
						state = (bq_loop_left == 0) ? ST_TSLEN : ST_DTAG;
					end
				end
				ST_DTAG: begin
					tag = b;
					state = ST_DLEN;
					if (count_loop()) close_loop();
				end
				ST_DLEN: begin
					ended = count_loop();
					left = in_ts ? ts_desc_left : bq_loop_left;
					desc_left = (b > left) ? left : b;
					byte_cnt = 0;
					shift = 0;
					name_cnt = 0;
					name_len = (desc_left > NAME_LIMIT) ? NAME_LIMIT : desc_left;
					if (tag == dbsp_pkg::TAG_NAME && name_len == 0) begin
						r = blank(dbsp_pkg::KIND_NAME);
						r.last_of_name = 1'b1;
						record_q.push_back(r);
					end
					if (ended) close_loop();
					else state = (desc_left == 0) ? ST_DTAG : ST_DBODY;
				end
				ST_DBODY: begin
					if (desc_left > 0) desc_left--;
					ended = count_loop();
					if (tag == dbsp_pkg::TAG_NAME) begin
						if (name_cnt < name_len) begin
							r = blank(dbsp_pkg::KIND_NAME);
							r.name_byte = b;
							r.name_length = name_len[4:0];
							r.last_of_name = (name_cnt + 1 == name_len);
							record_q.push_back(r);
							name_cnt++;
						end
					end else if (tag == dbsp_pkg::TAG_SERVICES) begin
						shift = {shift[39:0], b};
						byte_cnt++;
						if (byte_cnt >= 3) begin
							byte_cnt = 0;
							r = blank(dbsp_pkg::KIND_SERVICE);
							r.svc_id = shift[23:8];
							record_q.push_back(r);
						end
					end else if (tag == priv_tag_reg) begin
						shift = {shift[39:0], b};
						byte_cnt++;
						if (byte_cnt >= 6) begin
							byte_cnt = 0;
							bouquet = fixed_bq_reg;
							trk = shift[15:8];
							r = blank(dbsp_pkg::KIND_CHANNEL);
							r.svc_id = shift[47:32];
							r.channel_number = shift[31:16];
							r.audio_track = (trk <= 2) ? trk[1:0] : 2'd1;
							r.volume_offset = shift[7:0];
							record_q.push_back(r);
						end
					end
					if (ended) close_loop();
					else if (desc_left == 0) state = ST_DTAG;
				end
				ST_TSLEN: begin
					shift = {shift[39:0], b};
					byte_cnt++;
					if (byte_cnt >= 2) begin
						byte_cnt = 0;
						ts_loop_left = shift[11:0];
						state = (ts_loop_left == 0) ? ST_IDLE : ST_TSHDR;
					end
				end
				ST_TSHDR: begin
					shift = {shift[39:0], b};
					byte_cnt++;
					if (ts_loop_left > 0) ts_loop_left--;
					if (byte_cnt >= 6) begin
						byte_cnt = 0;
						ts_desc_left = shift[11:0];
						if (ts_desc_left > ts_loop_left) ts_desc_left = ts_loop_left;
						shift = 0;
						if (ts_desc_left > 0) begin
							in_ts = 1;
							state = ST_DTAG;
						end else if (ts_loop_left == 0) begin
							state = ST_IDLE;
						end
					end else if (ts_loop_left == 0) begin
						byte_cnt = 0;
						state = ST_IDLE;
					end
				end
				default: state = ST_IDLE;
			endcase
		endfunction

		function void check_record(dbsp_pkg::rec_t got);
			dbsp_pkg::rec_t want;
			records_seen++;
			if (record_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected record word %h", $realtime, got);
				return;
			end
			want = record_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t record mismatch: expected %p actual %p",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        section_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  record_kind;
	logic [15:0] bouquet_id;
	logic [4:0]  version;
	logic [7:0]  name_byte;
	logic [4:0]  name_length;
	logic [15:0] svc_id;
	logic [15:0] channel_number;
	logic [1:0]  audio_track;
	logic signed [7:0] volume_offset;
	logic        last_of_name;

	bat_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int sections_sent = 0;
	logic [7:0] cur_tid = 8'h4a;
	logic [7:0] cur_priv = 8'h80;

	dvb_bat_section_parser_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// monitor and watchdog: sample mid-cycle, act on the edge
	initial begin
		bit in_acc, out_acc;
		logic [7:0] mb;
		logic ms;
		dbsp_pkg::rec_t mr;
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			in_acc = arst_n && in_valid && !in_stall;
			out_acc = arst_n && out_valid && !out_stall;
			mb = data_byte;
			ms = section_start;
			mr = '{record_kind, bouquet_id, version, name_byte, name_length,
				svc_id, channel_number, audio_track, volume_offset, last_of_name};
			@(posedge clk);
			if (out_acc) sb.check_record(mr);
			if (in_acc) sb.note_byte(mb, ms);
			if (in_acc || out_acc) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("watchdog: no word moved for %0d cycles", quiet);
				$display("dvb_bat_section_parser_top_test: FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(logic [7:0] b, logic s);
		bit ok;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		section_start <= s;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.record_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_list(logic [7:0] q[$]);
		foreach (q[i]) send_word(q[i], i == 0);
		sections_sent++;
	endtask

	task automatic add_descriptors(ref logic [7:0] d[$]);
		int n, sel, len;
		logic [7:0] t;
		n = $urandom_range(0, 3);
		repeat (n) begin
			sel = $urandom_range(3);
			case (sel)
				0: begin t = dbsp_pkg::TAG_NAME; len = $urandom_range(0, 9) == 0 ?
					$urandom_range(31, 40) : $urandom_range(0, 12); end
				1: begin t = dbsp_pkg::TAG_SERVICES; len = $urandom_range(0, 10); end
				2: begin t = cur_priv; len = $urandom_range(0, 13); end
				default: begin t = 8'($urandom_range(255)); len = $urandom_range(0, 6); end
			endcase
			d.push_back(t);
			d.push_back(len[7:0]);
			repeat (len) d.push_back(8'($urandom_range(255)));
		end
	endtask

	function automatic int bend_len(int n);
		int m;
		m = $urandom_range(9);
		if (m == 0) return n + $urandom_range(1, 5);
		if (m == 1 && n > 0) return n - $urandom_range(1, n);
		return n;
	endfunction

	task automatic random_section();
		logic [7:0] q[$], d[$], t[$], e[$];
		int len, nts;
		q.push_back(($urandom_range(9) < 8) ? cur_tid : 8'($urandom_range(255)));
		repeat (5) q.push_back(8'($urandom_range(255)));
		q.push_back(8'($urandom_range(255)));
		q.push_back(8'($urandom_range(255)));
		add_descriptors(d);
		len = bend_len(d.size());
		q.push_back({4'($urandom_range(15)), 4'(len >> 8)});
		q.push_back(len[7:0]);
		q = {q, d};
		nts = $urandom_range(0, 2);
		repeat (nts) begin
			e.delete();
			add_descriptors(e);
			repeat (4) t.push_back(8'($urandom_range(255)));
			len = bend_len(e.size());
			t.push_back({4'($urandom_range(15)), 4'(len >> 8)});
			t.push_back(len[7:0]);
			t = {t, e};
		end
		len = bend_len(t.size());
		q.push_back({4'($urandom_range(15)), 4'(len >> 8)});
		q.push_back(len[7:0]);
		q = {q, t};
		repeat (4) q.push_back(8'($urandom_range(255)));
		send_list(q);
	endtask

	task automatic random_phase(int target, int idle, int stall, bit hold_off);
		int start_count;
		bit held;
		idle_pct = idle;
		stall_pct = stall;
		start_count = words_sent;
		held = 0;
		while (words_sent - start_count < target) begin
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 5))
					send_word(8'($urandom_range(255)), $urandom_range(4) == 0);
			end else begin
				random_section();
			end
			if (hold_off && !held && words_sent - start_count > target / 2) begin
				held = 1;
				drain();
			end
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short section: empty name, one service plus a partial entry, tag cut at loop end
		send_word(8'h55, 1'b0);
		send_list('{8'h4a, 8'h00, 8'h00, 8'h12, 8'h34, 8'hff, 8'h00, 8'h00,
			8'hf0, 8'h09, 8'h47, 8'h00, 8'h41, 8'h04, 8'haa, 8'hbb, 8'hcc, 8'hdd,
			8'h80, 8'h00, 8'h00});
		drain();

		random_phase(370, 0, 0, 1'b0);

		write_cfg(dbsp_pkg::CFG_TABLE_ID, 16'h0000);
		write_cfg(dbsp_pkg::CFG_PRIV_TAG, 16'h0000);
		write_cfg(dbsp_pkg::CFG_FIXED_BQ, 16'h0000);
		cur_tid = 8'h00; cur_priv = 8'h00;
		random_phase(370, 75, 0, 1'b1);

		write_cfg(dbsp_pkg::CFG_TABLE_ID, 16'h00ff);
		write_cfg(dbsp_pkg::CFG_PRIV_TAG, 16'h00ff);
		write_cfg(dbsp_pkg::CFG_FIXED_BQ, 16'hffff);
		cur_tid = 8'hff; cur_priv = 8'hff;
		random_phase(370, 0, 75, 1'b0);

		write_cfg(dbsp_pkg::CFG_TABLE_ID, 16'h004a);
		write_cfg(dbsp_pkg::CFG_PRIV_TAG, 16'(dbsp_pkg::TAG_NAME));
		cur_tid = 8'h4a; cur_priv = dbsp_pkg::TAG_NAME;
		random_phase(180, 20, 20, 1'b0);
		write_cfg(dbsp_pkg::CFG_PRIV_TAG, 16'(dbsp_pkg::TAG_SERVICES));
		cur_priv = dbsp_pkg::TAG_SERVICES;
		random_phase(180, 20, 20, 1'b0);

		cur_tid = 8'($urandom_range(255));
		cur_priv = 8'($urandom_range(255));
		write_cfg(dbsp_pkg::CFG_TABLE_ID, 16'(cur_tid));
		write_cfg(dbsp_pkg::CFG_PRIV_TAG, 16'(cur_priv));
		write_cfg(dbsp_pkg::CFG_FIXED_BQ, 16'($urandom_range(65535)));
		random_phase(370, 20, 20, 1'b0);

		repeat (20) @(posedge clk);
		$display("covered %0d input words in %0d sections over six register settings",
			words_sent, sections_sent);
		$display("checked %0d record words, %0d mismatches, %0d left over",
			sb.records_seen, sb.mismatches, sb.record_q.size());
		if (sb.mismatches == 0 && sb.record_q.size() == 0)
			$display("dvb_bat_section_parser_top_test: PASS");
		else
			$display("dvb_bat_section_parser_top_test: FAIL");
		$finish;
	end

endmodule
